### hdl/idbt_pkg.sv
package idbt_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SLOT_W = IDX_W + 1;
  localparam int MEM_DEPTH = 1 << SLOT_W;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // field widths
  localparam int TAG_W = 64;
  localparam int EID_W = 16;
  localparam int OWN_W = 32;
  localparam int USE_W = 8;

  typedef enum logic [1:0] {
    OP_BIND    = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // one stored binding
  typedef struct packed {
    logic [TAG_W-1:0] hit_high;
    logic [TAG_W-1:0] hit_low;
    logic             anonymous;
    logic [EID_W-1:0] eid;
    logic [OWN_W-1:0] uid;
    logic [OWN_W-1:0] gid;
    logic [OWN_W-1:0] pid;
    logic [OWN_W-1:0] flags;
    logic [USE_W-1:0] use_count;
  } entry_t;

endpackage

### hdl/identifier_binding_table.sv
// identifier_binding_table
// Binds 128-bit host identity tags to 16-bit endpoint identifiers in two
// tables (local and peer) of TABLE_ENTRIES slots each.
// Request channel: in_valid / in_stall with op, table_select, tag, owner
// fields and eid_value. Result channel: out_valid / out_stall, one result
// per request, fields not relevant to the op are zero.
// Each request scans every slot of the selected table through one memory
// read port, one slot per cycle, then moves to the finish step for the
// update and the result. An unused op code skips the scan and goes
// straight to the finish step. One request is in work at a time; in_stall
// is high until its result is loaded.
// A finished result sits in the output register; a new request may be taken
// while it waits. If the receiver stalls, the next result holds in the
// finish step until the output register frees up.
// Reset (rst, synchronous) clears all slot valid bits, sets both identifier
// counters to 1 and empties the output register; no clearing pass needed.
module identifier_binding_table
  import idbt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       op,
  input  logic             table_select,
  input  logic [TAG_W-1:0] hit_high,
  input  logic [TAG_W-1:0] hit_low,
  input  logic             anonymous_in,
  input  logic [OWN_W-1:0] owner_uid,
  input  logic [OWN_W-1:0] owner_gid,
  input  logic [OWN_W-1:0] owner_pid,
  input  logic [OWN_W-1:0] owner_flags,
  input  logic [EID_W-1:0] eid_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [EID_W-1:0] eid_out,
  output logic             created,
  output logic [TAG_W-1:0] hit_high_out,
  output logic [TAG_W-1:0] hit_low_out,
  output logic             anonymous_out,
  output logic [OWN_W-1:0] uid_out,
  output logic [OWN_W-1:0] gid_out,
  output logic [OWN_W-1:0] pid_out,
  output logic [OWN_W-1:0] flags_out
);

  state_t state, state_next;

  // slot memory and valid bits
  entry_t               mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] slot_valid;
  entry_t               rd_data;
  logic                 rd_vld;

  // latched request
  op_t              req_op;
  logic             req_local;
  logic [TAG_W-1:0] req_hi;
  logic [TAG_W-1:0] req_lo;
  logic             req_anon;
  logic [OWN_W-1:0] req_uid;
  logic [OWN_W-1:0] req_gid;
  logic [OWN_W-1:0] req_pid;
  logic [OWN_W-1:0] req_flags;
  logic [EID_W-1:0] req_eid;

  // scan bookkeeping
  logic [CNT_W-1:0] cnt;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic             found;
  logic [IDX_W-1:0] hit_idx;
  entry_t           hit_entry;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // identifier counters
  logic [EID_W-1:0] next_local_eid;
  logic [EID_W-1:0] next_peer_eid;
  logic [EID_W-1:0] ctr_cur;

  logic in_take;
  logic scan_done;
  logic rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic match;
  logic finish_go;

  // finish step decisions
  status_t           fin_status;
  logic [EID_W-1:0]  fin_eid;
  logic              fin_created;
  logic              fin_show;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              set_valid;
  logic              clr_valid;
  logic              ctr_inc;

  assign in_take   = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign scan_done = (cnt == CNT_W'(TABLE_ENTRIES)) && !rd_pend;
  assign rd_en     = (state == S_SCAN) && (cnt != CNT_W'(TABLE_ENTRIES));
  assign rd_addr   = {req_local, cnt[IDX_W-1:0]};
  assign finish_go = (state == S_FINISH) && (!out_valid || !out_stall);
  assign ctr_cur   = req_local ? next_local_eid : next_peer_eid;

  // compare of the slot read in the previous cycle
  always_comb begin
    if (req_op == OP_BIND) begin
      match = rd_vld && (rd_data.hit_high == req_hi) && (rd_data.hit_low == req_lo);
    end else begin
      match = rd_vld && (rd_data.eid == req_eid);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = (op_t'(op) == OP_UNUSED) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (finish_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // request latch and scan tracking
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_op    <= op_t'(op);
      req_local <= table_select;
      req_hi    <= hit_high;
      req_lo    <= hit_low;
      req_anon  <= anonymous_in;
      req_uid   <= owner_uid;
      req_gid   <= owner_gid;
      req_pid   <= owner_pid;
      req_flags <= owner_flags;
      req_eid   <= eid_value;
      cnt        <= '0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (state == S_SCAN) begin
      rd_pend <= rd_en;
      rd_idx  <= cnt[IDX_W-1:0];
      if (rd_en) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (rd_pend) begin
        if (match && !found) begin
          found     <= 1'b1;
          hit_idx   <= rd_idx;
          hit_entry <= rd_data;
        end
        if (!rd_vld && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end
    end
  end

  // slot memory, one read and one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= slot_valid[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // finish step: result and update
  always_comb begin
    fin_status  = ST_OK;
    fin_eid     = '0;
    fin_created = 1'b0;
    fin_show    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = {req_local, hit_idx};
    wr_data     = hit_entry;
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    ctr_inc     = 1'b0;
    case (req_op)
      OP_BIND: begin
        if (found) begin
          fin_eid = hit_entry.eid;
        end else if (!free_found) begin
          fin_status = ST_FULL;
        end else if (ctr_cur == '0) begin
          fin_status = ST_EXHAUSTED;
        end else begin
          fin_eid           = ctr_cur;
          fin_created       = 1'b1;
          wr_en             = 1'b1;
          wr_addr           = {req_local, free_idx};
          wr_data.hit_high  = req_hi;
          wr_data.hit_low   = req_lo;
          wr_data.anonymous = req_anon;
          wr_data.eid       = ctr_cur;
          wr_data.uid       = req_uid;
          wr_data.gid       = req_gid;
          wr_data.pid       = req_pid;
          wr_data.flags     = req_flags;
          wr_data.use_count = USE_W'(1);
          set_valid         = 1'b1;
          ctr_inc           = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (found && (req_eid != '0)) begin
          fin_show = 1'b1;
        end else begin
          fin_status = ST_NOT_FOUND;
        end
      end
      OP_RELEASE: begin
        if (found && (req_eid != '0)) begin
          if (hit_entry.use_count <= USE_W'(1)) begin
            clr_valid = 1'b1;
          end else begin
            wr_en             = 1'b1;
            wr_data.use_count = hit_entry.use_count - USE_W'(1);
          end
        end else begin
          fin_status = ST_NOT_FOUND;
        end
      end
      default: fin_status = ST_NOT_FOUND;
    endcase
    if (!finish_go) begin
      wr_en     = 1'b0;
      set_valid = 1'b0;
      clr_valid = 1'b0;
      ctr_inc   = 1'b0;
    end
  end

  // valid bits and identifier counters
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid     <= '0;
      next_local_eid <= EID_W'(1);
      next_peer_eid  <= EID_W'(1);
    end else begin
      if (set_valid) begin
        slot_valid[wr_addr] <= 1'b1;
      end
      if (clr_valid) begin
        slot_valid[wr_addr] <= 1'b0;
      end
      if (ctr_inc) begin
        if (req_local) begin
          next_local_eid <= next_local_eid + EID_W'(1);
        end else begin
          next_peer_eid <= next_peer_eid + EID_W'(1);
        end
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (finish_go) begin
      status        <= fin_status;
      eid_out       <= fin_eid;
      created       <= fin_created;
      hit_high_out  <= fin_show ? hit_entry.hit_high : '0;
      hit_low_out   <= fin_show ? hit_entry.hit_low : '0;
      anonymous_out <= fin_show ? hit_entry.anonymous : 1'b0;
      uid_out       <= fin_show ? hit_entry.uid : '0;
      gid_out       <= fin_show ? hit_entry.gid : '0;
      pid_out       <= fin_show ? hit_entry.pid : '0;
      flags_out     <= fin_show ? hit_entry.flags : '0;
    end
  end

endmodule
